### design/wtsp_pkg.sv
// Shared types and fixed constants of the world-to-screen projection block.
package wtsp_pkg;

   localparam int WORD_W    = 32;
   localparam int DIM_W     = 14;
   localparam int HALF_W    = DIM_W - 1;
   localparam int MAT_DEPTH = 16;
   localparam int MAT_AW    = 4;
   localparam int NDC_LOG2  = 40;
   localparam int NDC_W     = NDC_LOG2 + 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 14'd1024;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd768;

   localparam logic ACTION_LOAD      = 1'b0;
   localparam logic ACTION_TRANSFORM = 1'b1;

   typedef struct packed {
      logic load;
      logic mul;
      logic acc;
   } mac_ctl_type;

endpackage

### design/wtsp_mac.sv
// Shared multiply-accumulate unit that forms the clip coordinates one product at a time.
module wtsp_mac #(
   parameter int FRAC_BITS = 16,
   parameter int ACC_W     = 51
) (
   input  logic                                 clock,
   input  wtsp_pkg::mac_ctl_type                ctl,
   input  logic signed [wtsp_pkg::WORD_W-1:0]   bias,
   input  logic signed [wtsp_pkg::WORD_W-1:0]   mul_a,
   input  logic signed [wtsp_pkg::WORD_W-1:0]   mul_b,
   output logic signed [ACC_W-1:0]              acc
);
   import wtsp_pkg::*;

   logic signed [2*WORD_W-1:0] prod_ff, prod_in;
   logic signed [2*WORD_W-1:0] prod_floor;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;

   always_comb begin
      prod_in    = mul_a * mul_b;
      // Arithmetic shift floors the exact product to the fraction width.
      prod_floor = prod_ff >>> FRAC_BITS;
      acc_in     = acc_ff;
      if (ctl.load) begin
         acc_in = ACC_W'(bias);
      end else if (ctl.acc) begin
         acc_in = acc_ff + ACC_W'(prod_floor);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

### design/wtsp_div.sv
// Bit-serial fixed-point divider with magnitude clamp, one quotient bit per cycle.
module wtsp_div #(
   parameter int FRAC_BITS = 16,
   parameter int ACC_W     = 51
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [ACC_W-1:0]             num,
   input  logic signed [ACC_W-1:0]             den,
   output logic                                done,
   output logic signed [wtsp_pkg::NDC_W-1:0]   quot
);
   import wtsp_pkg::*;

   localparam int SHIFT_W = NDC_LOG2 - FRAC_BITS;
   localparam int REM_W   = ACC_W - 1;
   localparam int CMP_W   = ACC_W + SHIFT_W;
   localparam int CNT_W   = $clog2(NDC_LOG2);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(NDC_LOG2 - 1);

   localparam logic [1:0] D_IDLE  = 2'd0;
   localparam logic [1:0] D_CHECK = 2'd1;
   localparam logic [1:0] D_ITER  = 2'd2;

   logic [1:0]              st_ff, st_in;
   logic                    neg_ff, neg_in;
   logic [ACC_W-1:0]        an_ff, an_in;
   logic [REM_W-1:0]        den_ff, den_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [NDC_LOG2-1:0]     lo_ff, lo_in;
   logic [NDC_LOG2-1:0]     q_ff, q_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic signed [NDC_W-1:0] quot_ff, quot_in;

   logic                    overflow;
   logic [ACC_W-1:0]        trial;
   logic [ACC_W-1:0]        diff;
   logic                    ge;
   logic [NDC_LOG2:0]       mag;
   logic signed [NDC_W-1:0] mag_s;

   always_comb begin
      // The quotient reaches the clamp exactly when the dividend is at least
      // the divisor scaled up by the integer-part limit.
      overflow = {{SHIFT_W{1'b0}}, an_ff} >= {1'b0, den_ff, {SHIFT_W{1'b0}}};
      trial    = {rem_ff, lo_ff[NDC_LOG2-1]};
      diff     = trial - {1'b0, den_ff};
      ge       = trial >= {1'b0, den_ff};
      mag      = {1'b0, q_ff};
      mag_s    = '0;

      st_in   = st_ff;
      neg_in  = neg_ff;
      an_in   = an_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quot_in = quot_ff;

      case (st_ff)
         D_IDLE: begin
            if (start) begin
               neg_in = num[ACC_W-1];
               an_in  = num[ACC_W-1] ? (~num + ACC_W'(1)) : num;
               den_in = den[REM_W-1:0];
               st_in  = D_CHECK;
            end
         end
         D_CHECK: begin
            if (overflow) begin
               mag     = {1'b1, {NDC_LOG2{1'b0}}};
               mag_s   = $signed({1'b0, mag});
               quot_in = neg_ff ? -mag_s : mag_s;
               done_in = 1'b1;
               st_in   = D_IDLE;
            end else begin
               rem_in = REM_W'(an_ff >> SHIFT_W);
               lo_in  = {an_ff[SHIFT_W-1:0], {FRAC_BITS{1'b0}}};
               q_in   = '0;
               cnt_in = '0;
               st_in  = D_ITER;
            end
         end
         D_ITER: begin
            rem_in = ge ? REM_W'(diff) : REM_W'(trial);
            lo_in  = {lo_ff[NDC_LOG2-2:0], 1'b0};
            q_in   = {q_ff[NDC_LOG2-2:0], ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_BIT) begin
               mag     = {1'b0, q_in};
               mag_s   = $signed({1'b0, mag});
               quot_in = neg_ff ? -mag_s : mag_s;
               done_in = 1'b1;
               st_in   = D_IDLE;
            end
         end
         default: begin
            st_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= D_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      an_ff   <= an_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

### design/wtsp_map.sv
// Viewport mapping: scales both normalised coordinates on one multiplier and saturates.
module wtsp_map #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [wtsp_pkg::NDC_W-1:0]    ndc_x,
   input  logic signed [wtsp_pkg::NDC_W-1:0]    ndc_y,
   input  logic [wtsp_pkg::HALF_W-1:0]          half_w,
   input  logic [wtsp_pkg::HALF_W-1:0]          half_h,
   output logic                                 done,
   output logic signed [wtsp_pkg::WORD_W-1:0]   screen_x,
   output logic signed [wtsp_pkg::WORD_W-1:0]   screen_y
);
   import wtsp_pkg::*;

   localparam int FAC_W  = HALF_W + 2;
   localparam int PROD_W = NDC_W + FAC_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int OFF_W  = HALF_W + FRAC_BITS;

   localparam logic signed [FAC_W-1:0]  ONE_FAC = FAC_W'(1);
   localparam logic signed [SUM_W-1:0]  SAT_MAX = SUM_W'(64'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0]  SAT_MIN = SUM_W'(-64'sh8000_0000);
   localparam logic [WORD_W-1:0]        WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0]        WORD_MIN = 32'h8000_0000;

   localparam logic [1:0] M_IDLE = 2'd0;
   localparam logic [1:0] M_X    = 2'd1;
   localparam logic [1:0] M_Y    = 2'd2;

   logic [1:0]               ph_ff, ph_in;
   logic                     done_ff, done_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [WORD_W-1:0] sx_ff, sx_in;
   logic signed [WORD_W-1:0] sy_ff, sy_in;

   logic signed [FAC_W-1:0]  fac_x, fac_y, mul_fac;
   logic signed [NDC_W-1:0]  mul_ndc;
   logic [OFF_W-1:0]         off;
   logic signed [SUM_W-1:0]  sum;
   logic [WORD_W-1:0]        sat_val;

   always_comb begin
      // Keeps the original formula: (hw + 1) * ndc_x and (1 - hh) * ndc_y.
      fac_x   = $signed({2'b00, half_w}) + ONE_FAC;
      fac_y   = ONE_FAC - $signed({2'b00, half_h});
      mul_fac = (ph_ff == M_IDLE) ? fac_x : fac_y;
      mul_ndc = (ph_ff == M_IDLE) ? ndc_x : ndc_y;
      prod_in = mul_fac * mul_ndc;

      off = (ph_ff == M_X) ? {half_w, {FRAC_BITS{1'b0}}} : {half_h, {FRAC_BITS{1'b0}}};
      sum = $signed({prod_ff[PROD_W-1], prod_ff})
          + $signed({{(SUM_W - OFF_W){1'b0}}, off});
      if (sum > SAT_MAX) begin
         sat_val = WORD_MAX;
      end else if (sum < SAT_MIN) begin
         sat_val = WORD_MIN;
      end else begin
         sat_val = sum[WORD_W-1:0];
      end

      ph_in   = ph_ff;
      done_in = 1'b0;
      sx_in   = sx_ff;
      sy_in   = sy_ff;
      case (ph_ff)
         M_IDLE: begin
            if (start) begin
               ph_in = M_X;
            end
         end
         M_X: begin
            sx_in = $signed(sat_val);
            ph_in = M_Y;
         end
         M_Y: begin
            sy_in   = $signed(sat_val);
            done_in = 1'b1;
            ph_in   = M_IDLE;
         end
         default: begin
            ph_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= M_IDLE;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= done_in;
      end
      prod_ff <= prod_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
   end

   assign done     = done_ff;
   assign screen_x = sx_ff;
   assign screen_y = sy_ff;

endmodule

### design/world_to_screen_projection_top.sv
// Processing: a transform item runs the three matrix rows, the w check, one division per
// coordinate, the viewport map and the output register when visible; when hidden it skips
// the divisions and the map. A clamped division ends early, without its bit-serial steps.
// The bit-serial divider sets the rate: a new request is taken only once the previous item
// has reached the output register, and a load item is written while the block is idle.
// Synchronous reset clears the view matrix to zero and sets the window to 1024 x 768.
module world_to_screen_projection_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic [wtsp_pkg::MAT_AW-1:0]          req_matrix_index,
   input  logic signed [wtsp_pkg::WORD_W-1:0]   req_matrix_value,
   input  logic signed [wtsp_pkg::WORD_W-1:0]   req_pos_x,
   input  logic signed [wtsp_pkg::WORD_W-1:0]   req_pos_y,
   input  logic signed [wtsp_pkg::WORD_W-1:0]   req_pos_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_visible,
   output logic signed [wtsp_pkg::WORD_W-1:0]   rsp_screen_x,
   output logic signed [wtsp_pkg::WORD_W-1:0]   rsp_screen_y,
   input  logic                                 csr_wr_en,
   input  logic [wtsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wtsp_pkg::DIM_W-1:0]           csr_wr_data
);
   import wtsp_pkg::*;

   localparam int ACC_W = 2 * WORD_W + 3 - FRAC_BITS;
   localparam logic signed [ACC_W-1:0] TENTH_Q = ACC_W'(((1 << FRAC_BITS) + 5) / 10);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MAC   = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_DIVX  = 3'd3;
   localparam logic [2:0] S_DIVY  = 3'd4;
   localparam logic [2:0] S_MAP   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   localparam logic [2:0] STEP_BIAS  = 3'd0;
   localparam logic [2:0] STEP_X     = 3'd1;
   localparam logic [2:0] STEP_Y     = 3'd2;
   localparam logic [2:0] STEP_Z     = 3'd3;
   localparam logic [2:0] STEP_DRAIN = 3'd4;
   localparam logic [2:0] STEP_STORE = 3'd5;

   localparam logic [1:0] ROW_X    = 2'd0;
   localparam logic [1:0] ROW_Y    = 2'd1;
   localparam logic [1:0] ROW_LAST = 2'd2;
   localparam logic [1:0] ROW_W    = 2'd3;
   localparam logic [1:0] COL_BIAS = 2'd3;

   logic [2:0]               state_ff, state_in;
   logic [1:0]               rc_ff, rc_in;
   logic [2:0]               step_ff, step_in;
   logic signed [WORD_W-1:0] pos_x_ff, pos_x_in;
   logic signed [WORD_W-1:0] pos_y_ff, pos_y_in;
   logic signed [WORD_W-1:0] pos_z_ff, pos_z_in;
   logic [WORD_W-1:0]        mat_ff [MAT_DEPTH];
   logic [DIM_W-1:0]         width_ff;
   logic [DIM_W-1:0]         height_ff;
   logic signed [ACC_W-1:0]  cx_ff, cx_in;
   logic signed [ACC_W-1:0]  cy_ff, cy_in;
   logic signed [ACC_W-1:0]  cw_ff, cw_in;
   logic signed [NDC_W-1:0]  nx_ff, nx_in;
   logic signed [NDC_W-1:0]  ny_ff, ny_in;
   logic                     vis_ff, vis_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_visible_ff, rsp_visible_in;
   logic signed [WORD_W-1:0] rsp_sx_ff, rsp_sx_in;
   logic signed [WORD_W-1:0] rsp_sy_ff, rsp_sy_in;

   logic                     mat_we;
   logic [1:0]               mat_row;
   logic [1:0]               mat_col;
   logic [WORD_W-1:0]        mat_rd;
   logic signed [WORD_W-1:0] coord;
   mac_ctl_type              mac_ctl;
   logic signed [ACC_W-1:0]  mac_acc;
   logic                     div_start;
   logic signed [ACC_W-1:0]  div_num;
   logic                     div_done;
   logic signed [NDC_W-1:0]  div_quot;
   logic                     map_start;
   logic                     map_done;
   logic signed [WORD_W-1:0] map_sx;
   logic signed [WORD_W-1:0] map_sy;

   // Matrix word addressing: column-major, so address = column * 4 + row.
   always_comb begin
      mat_row = (rc_ff == ROW_LAST) ? ROW_W : rc_ff;
      case (step_ff)
         STEP_X: begin
            mat_col = 2'd0;
            coord   = pos_x_ff;
         end
         STEP_Y: begin
            mat_col = 2'd1;
            coord   = pos_y_ff;
         end
         STEP_Z: begin
            mat_col = 2'd2;
            coord   = pos_z_ff;
         end
         default: begin
            mat_col = COL_BIAS;
            coord   = pos_z_ff;
         end
      endcase
      mat_rd = mat_ff[{mat_col, mat_row}];
   end

   always_comb begin
      state_in       = state_ff;
      rc_in          = rc_ff;
      step_in        = step_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      pos_z_in       = pos_z_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      cw_in          = cw_ff;
      nx_in          = nx_ff;
      ny_in          = ny_ff;
      vis_in         = vis_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_visible_in = rsp_visible_ff;
      rsp_sx_in      = rsp_sx_ff;
      rsp_sy_in      = rsp_sy_ff;
      mat_we         = 1'b0;
      mac_ctl        = '0;
      div_start      = 1'b0;
      map_start      = 1'b0;
      div_num        = (state_ff == S_CHECK) ? cx_ff : cy_ff;
      req_stall      = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == ACTION_TRANSFORM) begin
                  pos_x_in = req_pos_x;
                  pos_y_in = req_pos_y;
                  pos_z_in = req_pos_z;
                  rc_in    = ROW_X;
                  step_in  = STEP_BIAS;
                  state_in = S_MAC;
               end else begin
                  mat_we = 1'b1;
               end
            end
         end
         S_MAC: begin
            mac_ctl.load = (step_ff == STEP_BIAS);
            mac_ctl.mul  = (step_ff == STEP_X) || (step_ff == STEP_Y) || (step_ff == STEP_Z);
            mac_ctl.acc  = (step_ff == STEP_Y) || (step_ff == STEP_Z)
                        || (step_ff == STEP_DRAIN);
            if (step_ff == STEP_STORE) begin
               case (rc_ff)
                  ROW_X:   cx_in = mac_acc;
                  ROW_Y:   cy_in = mac_acc;
                  default: cw_in = mac_acc;
               endcase
               step_in = STEP_BIAS;
               if (rc_ff == ROW_LAST) begin
                  state_in = S_CHECK;
               end else begin
                  rc_in = rc_ff + 2'd1;
               end
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_CHECK: begin
            if (cw_ff < TENTH_Q) begin
               vis_in   = 1'b0;
               state_in = S_OUT;
            end else begin
               vis_in    = 1'b1;
               div_start = 1'b1;
               state_in  = S_DIVX;
            end
         end
         S_DIVX: begin
            if (div_done) begin
               nx_in     = div_quot;
               div_start = 1'b1;
               state_in  = S_DIVY;
            end
         end
         S_DIVY: begin
            if (div_done) begin
               ny_in     = div_quot;
               map_start = 1'b1;
               state_in  = S_MAP;
            end
         end
         S_MAP: begin
            if (map_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // The output register frees up in the same cycle its item is taken.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_visible_in = vis_ff;
               rsp_sx_in      = vis_ff ? map_sx : '0;
               rsp_sy_in      = vis_ff ? map_sy : '0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         for (int i = 0; i < MAT_DEPTH; i++) begin
            mat_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mat_we) begin
            mat_ff[req_matrix_index] <= req_matrix_value;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WINDOW_WIDTH:  width_ff  <= csr_wr_data;
               CSR_WINDOW_HEIGHT: height_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
      rc_ff          <= rc_in;
      step_ff        <= step_in;
      pos_x_ff       <= pos_x_in;
      pos_y_ff       <= pos_y_in;
      pos_z_ff       <= pos_z_in;
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      cw_ff          <= cw_in;
      nx_ff          <= nx_in;
      ny_ff          <= ny_in;
      vis_ff         <= vis_in;
      rsp_visible_ff <= rsp_visible_in;
      rsp_sx_ff      <= rsp_sx_in;
      rsp_sy_ff      <= rsp_sy_in;
   end

   wtsp_mac #(
      .FRAC_BITS (FRAC_BITS),
      .ACC_W     (ACC_W)
   ) u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .bias  ($signed(mat_rd)),
      .mul_a (coord),
      .mul_b ($signed(mat_rd)),
      .acc   (mac_acc)
   );

   wtsp_div #(
      .FRAC_BITS (FRAC_BITS),
      .ACC_W     (ACC_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (cw_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   wtsp_map #(
      .FRAC_BITS (FRAC_BITS)
   ) u_map (
      .clock    (clock),
      .reset    (reset),
      .start    (map_start),
      .ndc_x    (nx_ff),
      .ndc_y    (ny_ff),
      .half_w   (width_ff[DIM_W-1:1]),
      .half_h   (height_ff[DIM_W-1:1]),
      .done     (map_done),
      .screen_x (map_sx),
      .screen_y (map_sy)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_visible  = rsp_visible_ff;
   assign rsp_screen_x = rsp_sx_ff;
   assign rsp_screen_y = rsp_sy_ff;

`ifndef SYNTHESIS
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result became valid outside the output state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIVX) || (state_ff == S_DIVY))
      else $error("divider finished while no division was pending");

   a_map_done_state: assert property (@(posedge clock) disable iff (reset)
      map_done |-> state_ff == S_MAP)
      else $error("viewport map finished outside the map state");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_visible_ff |-> (rsp_sx_ff == '0) && (rsp_sy_ff == '0))
      else $error("hidden point carries non-zero screen coordinates");
`endif

endmodule

### bench/tb_world_to_screen_projection_top.sv
// Self-checking testbench for the world-to-screen projection block, with a built-in predictor.
module tb_world_to_screen_projection_top;
   import wtsp_pkg::*;

   localparam int FRAC = 16;
   localparam longint TENTH = ((64'sd1 <<< FRAC) + 5) / 10;
   localparam int DRAIN_CYCLES = 120;
   localparam int RANDOM_ITEMS = 1700;
   localparam int PHASES = 8;

   typedef struct {
      logic                     action;
      logic [MAT_AW-1:0]        matrix_index;
      logic signed [WORD_W-1:0] matrix_value;
      logic signed [WORD_W-1:0] pos_x;
      logic signed [WORD_W-1:0] pos_y;
      logic signed [WORD_W-1:0] pos_z;
   } req_item_type;

   typedef struct packed {
      logic                     visible;
      logic signed [WORD_W-1:0] screen_x;
      logic signed [WORD_W-1:0] screen_y;
   } screen_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_action = ACTION_LOAD;
   logic [MAT_AW-1:0]        req_matrix_index = '0;
   logic signed [WORD_W-1:0] req_matrix_value = '0;
   logic signed [WORD_W-1:0] req_pos_x = '0;
   logic signed [WORD_W-1:0] req_pos_y = '0;
   logic signed [WORD_W-1:0] req_pos_z = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_visible;
   logic signed [WORD_W-1:0] rsp_screen_x;
   logic signed [WORD_W-1:0] rsp_screen_y;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_WINDOW_WIDTH;
   logic [DIM_W-1:0]         csr_wr_data = '0;

   // Predictor copy of the matrix and the window registers.
   logic signed [WORD_W-1:0] view_mat [MAT_DEPTH];
   logic [DIM_W-1:0]         win_w = WIDTH_RESET;
   logic [DIM_W-1:0]         win_h = HEIGHT_RESET;

   req_item_type pending_q[$];
   screen_type   expected_q[$];
   req_item_type on_port;
   screen_type   due;
   int n_queued = 0;
   int n_accepted = 0;
   int n_errors = 0;
   int req_gap = 0;
   int req_quiet = 0;
   int rsp_hold = 0;
   int rsp_quiet = 0;

   world_to_screen_projection_top #(.FRAC_BITS(FRAC)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_matrix_index(req_matrix_index),
      .req_matrix_value(req_matrix_value),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_visible(rsp_visible),
      .rsp_screen_x(rsp_screen_x),
      .rsp_screen_y(rsp_screen_y),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   initial forever #5 clock = ~clock;

   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

   // One row of the matrix product; each product is floored before the exact sum.
   function automatic longint clip_row(longint px, longint py, longint pz, int r);
      longint acc;
      acc = longint'(view_mat[12 + r]);
      acc += (px * longint'(view_mat[r])) >>> FRAC;
      acc += (py * longint'(view_mat[4 + r])) >>> FRAC;
      acc += (pz * longint'(view_mat[8 + r])) >>> FRAC;
      return acc;
   endfunction

   // Quotient truncated toward zero, its magnitude capped at 2^40.
   function automatic longint ndc_divide(longint num, longint den);
      bit [127:0] mag;
      bit [127:0] divisor;
      mag = 128'((num < 0) ? -num : num);
      divisor = 128'(den);
      mag = (mag << FRAC) / divisor;
      if (mag > (128'd1 << NDC_LOG2))
         mag = 128'd1 << NDC_LOG2;
      return (num < 0) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_word(longint v);
      if (v > 64'sh7FFFFFFF)
         return 32'sh7FFFFFFF;
      if (v < -64'sh80000000)
         return 32'sh80000000;
      return v[WORD_W-1:0];
   endfunction

   function automatic screen_type project_point(req_item_type pt);
      longint cx, cy, cw, nx, ny, hw, hh;
      screen_type res;
      cx = clip_row(pt.pos_x, pt.pos_y, pt.pos_z, 0);
      cy = clip_row(pt.pos_x, pt.pos_y, pt.pos_z, 1);
      cw = clip_row(pt.pos_x, pt.pos_y, pt.pos_z, 3);
      res = '0;
      if (cw >= TENTH) begin
         nx = ndc_divide(cx, cw);
         ny = ndc_divide(cy, cw);
         hw = longint'(win_w >> 1);
         hh = longint'(win_h >> 1);
         res.visible = 1'b1;
         res.screen_x = sat_word((hw + 1) * nx + (hw <<< FRAC));
         res.screen_y = sat_word((1 - hh) * ny + (hh <<< FRAC));
      end
      return res;
   endfunction

   // Mostly no pause, sometimes a short one, rarely a long one, now and then a calm stretch.
   function automatic int draw_gap(inout int quiet);
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         quiet = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         foreach (view_mat[i])
            view_mat[i] = '0;
      end else begin
         if (req_valid && !req_stall) begin
            n_accepted++;
            if (on_port.action == ACTION_LOAD)
               view_mat[on_port.matrix_index] = on_port.matrix_value;
            else
               expected_q.push_back(project_point(on_port));
         end
         // A stalled item stays on the port untouched.
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               on_port = pending_q.pop_front();
               req_valid <= 1'b1;
               req_action <= on_port.action;
               req_matrix_index <= on_port.matrix_index;
               req_matrix_value <= on_port.matrix_value;
               req_pos_x <= on_port.pos_x;
               req_pos_y <= on_port.pos_y;
               req_pos_z <= on_port.pos_z;
               req_gap = draw_gap(req_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic signed [WORD_W-1:0] want,
                              logic signed [WORD_W-1:0] got);
      if (want !== got) begin
         n_errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               n_errors++;
               $display("%0t: unexpected result, expected none, got visible %0d x %0d y %0d",
                        $time, rsp_visible, rsp_screen_x, rsp_screen_y);
            end else begin
               due = expected_q.pop_front();
               check_field("visible", {31'b0, due.visible}, {31'b0, rsp_visible});
               check_field("screen_x", due.screen_x, rsp_screen_x);
               check_field("screen_y", due.screen_y, rsp_screen_y);
            end
         end
         rsp_hold = (rsp_hold > 0) ? rsp_hold - 1 : draw_gap(rsp_quiet);
         rsp_stall <= (rsp_hold != 0);
      end
   end

   task automatic push_load(int idx, logic signed [WORD_W-1:0] value);
      req_item_type pt;
      pt.action = ACTION_LOAD;
      pt.matrix_index = MAT_AW'(idx);
      pt.matrix_value = value;
      pt.pos_x = $urandom;
      pt.pos_y = $urandom;
      pt.pos_z = $urandom;
      pending_q.push_back(pt);
      n_queued++;
   endtask

   task automatic push_point(logic signed [WORD_W-1:0] x, logic signed [WORD_W-1:0] y,
                             logic signed [WORD_W-1:0] z);
      req_item_type pt;
      pt.action = ACTION_TRANSFORM;
      pt.matrix_index = MAT_AW'($urandom);
      pt.matrix_value = $urandom;
      pt.pos_x = x;
      pt.pos_y = y;
      pt.pos_z = z;
      pending_q.push_back(pt);
      n_queued++;
   endtask

   // Coordinates: mostly within a hundred units, some full range, a few at the extremes.
   function automatic logic signed [WORD_W-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         1, 2, 3: return $urandom;
         default: return int'($urandom_range(0, 13107200)) - 6553600;
      endcase
   endfunction

   function automatic logic signed [WORD_W-1:0] rand_mat_word();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         1, 2: return $urandom;
         default: return int'($urandom_range(0, 524288)) - 262144;
      endcase
   endfunction

   // A plausible camera: a positive w offset and weak w slopes keep many points visible.
   task automatic push_scene();
      int n;
      for (int i = 0; i < MAT_DEPTH; i++) begin
         if (i == 15)
            push_load(i, $urandom_range(4096, 655360));
         else if (i % 4 == 3)
            push_load(i, int'($urandom_range(0, 2048)) - 1024);
         else
            push_load(i, rand_mat_word());
      end
      n = $urandom_range(3, 12);
      repeat (n) push_point(rand_coord(), rand_coord(), rand_coord());
   endtask

   task automatic fill_random(int count);
      int target;
      target = n_queued + count;
      while (n_queued < target) begin
         case ($urandom_range(0, 19))
            15, 16, 17: begin
               repeat ($urandom_range(1, 4)) push_load($urandom_range(0, 15), rand_mat_word());
               repeat ($urandom_range(2, 6)) push_point(rand_coord(), rand_coord(), rand_coord());
            end
            18, 19: begin
               repeat ($urandom_range(1, 8)) begin
                  if ($urandom_range(0, 1))
                     push_load($urandom_range(0, 15), $urandom);
                  else
                     push_point($urandom, $urandom, $urandom);
               end
            end
            default: push_scene();
         endcase
      end
   endtask

   task automatic wait_drained();
      while (n_accepted != n_queued || expected_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_window(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      wait_drained();
      // A trailing load item gives no result, so allow the block time to settle.
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_WINDOW_WIDTH;
      csr_wr_data <= w;
      @(posedge clock);
      csr_index <= CSR_WINDOW_HEIGHT;
      csr_wr_data <= h;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      win_w = w;
      win_h = h;
      @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // With the matrix still cleared, clip w is zero and the point is hidden.
      push_point($urandom, $urandom, $urandom);
      // Clip w one step below and exactly at one tenth.
      push_load(15, WORD_W'(TENTH - 1));
      push_point($urandom, $urandom, $urandom);
      push_load(15, WORD_W'(TENTH));
      push_point($urandom, $urandom, $urandom);
      push_load(12, 32'sh7FFFFFFF);
      push_load(13, 32'sh80000000);
      push_point(0, 0, 0);
      // Huge clip x and y over a tiny w: the quotient hits its cap.
      push_load(0, 32'sh7FFFFFFF);
      push_load(5, 32'sh80000000);
      push_point(32'sh7FFFFFFF, 32'sh80000000, 0);
      push_point(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      // Negative w slope: one side of the x range falls behind the camera.
      push_load(3, 32'sh80000000);
      push_point(32'sh7FFFFFFF, 0, 0);
      push_point(32'sh80000000, 0, 0);
      push_load(3, 0);
      push_load(14, 32'sh7FFFFFFF);
      push_load(11, 32'sh00010000);
      push_point(0, 0, 32'sh7FFFFFFF);
      push_point(0, 0, 32'sh80000000);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: write_window(DIM_W'(0), DIM_W'(0));
            1: write_window(DIM_W'(1), DIM_W'(1));
            2: write_window(DIM_W'(8192), DIM_W'(8192));
            3: write_window(14'h3FFF, 14'h3FFF);
            4: write_window(DIM_W'(2), DIM_W'(3));
            5: write_window(WIDTH_RESET, HEIGHT_RESET);
            default: write_window(DIM_W'($urandom_range(1, 8192)),
                                  DIM_W'($urandom_range(1, 8192)));
         endcase
         fill_random(RANDOM_ITEMS / PHASES);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### sim.f
design/wtsp_pkg.sv
design/wtsp_mac.sv
design/wtsp_div.sv
design/wtsp_map.sv
design/world_to_screen_projection_top.sv
bench/tb_world_to_screen_projection_top.sv
